FILE: rtl/tlvef_pkg.sv
// shared types, codes and helpers for the tlv element end finder
package tlvef_pkg;

   // octets that announce an extended type or length
   localparam logic [7:0] EXT2_OCTET = 8'd253;
   localparam logic [7:0] EXT4_OCTET = 8'd254;

   localparam logic [3:0] EXT2_BYTES = 4'd2;
   localparam logic [3:0] EXT4_BYTES = 4'd4;
   localparam logic [3:0] EXT8_BYTES = 4'd8;

   // phase codes as seen on the result channel
   localparam logic [2:0] PHASE_CODE_TYPE         = 3'd0;
   localparam logic [2:0] PHASE_CODE_TYPE_BYTES   = 3'd1;
   localparam logic [2:0] PHASE_CODE_LENGTH       = 3'd2;
   localparam logic [2:0] PHASE_CODE_LENGTH_BYTES = 3'd3;
   localparam logic [2:0] PHASE_CODE_VALUE        = 3'd4;
   localparam logic [2:0] PHASE_CODE_DONE         = 3'd5;

   typedef enum logic [5:0] {
      PH_TYPE         = 6'b000001,
      PH_TYPE_BYTES   = 6'b000010,
      PH_LENGTH       = 6'b000100,
      PH_LENGTH_BYTES = 6'b001000,
      PH_VALUE        = 6'b010000,
      PH_DONE         = 6'b100000
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       mode;
   } req_payload_type;

   typedef struct packed {
      logic        element_end;
      logic        ignored;
      logic [2:0]  phase;
      logic [31:0] bytes_consumed;
   } rsp_payload_type;

   typedef struct packed {
      phase_type   phase;
      logic [3:0]  header_left;
      logic [63:0] value_left;
      logic        end_reached;
   } parse_state_type;

   function automatic logic [3:0] ext_bytes(input logic [7:0] octet);
      logic [3:0] n;
      if (octet == EXT2_OCTET) begin
         n = EXT2_BYTES;
      end else if (octet == EXT4_OCTET) begin
         n = EXT4_BYTES;
      end else begin
         n = EXT8_BYTES;
      end
      return n;
   endfunction

   function automatic logic [2:0] phase_code(input phase_type ph);
      logic [2:0] c;
      case (ph)
         PH_TYPE:         c = PHASE_CODE_TYPE;
         PH_TYPE_BYTES:   c = PHASE_CODE_TYPE_BYTES;
         PH_LENGTH:       c = PHASE_CODE_LENGTH;
         PH_LENGTH_BYTES: c = PHASE_CODE_LENGTH_BYTES;
         PH_VALUE:        c = PHASE_CODE_VALUE;
         default:         c = PHASE_CODE_DONE;
      endcase
      return c;
   endfunction

endpackage

FILE: rtl/tlvef_stream_if.sv
// valid/ready stream channel carrying one payload per transfer
interface tlvef_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

FILE: rtl/tlv_element_end_finder.sv
// A result is valid on the cycle after its byte transfers in.
// Throughput: one byte per cycle while results are taken; the parse state updates on each transfer.
// A result register decouples the sides: a byte is taken while a result
// waits, as long as that result leaves in the same cycle.
// Reset (synchronous) returns the parser to the type phase with zero counts
// and empties the result register.
module tlv_element_end_finder #(
   parameter int COUNT_WIDTH = 32
) (
   input logic            clock,
   input logic            reset,
   tlvef_stream_if.sink   req_if,
   tlvef_stream_if.source rsp_if
);

   localparam int CntW = (COUNT_WIDTH < 32) ? COUNT_WIDTH : 32;

   tlvef_pkg::parse_state_type state_ff;
   tlvef_pkg::parse_state_type state_in;
   logic [CntW-1:0]            count_ff;
   logic [CntW-1:0]            count_in;
   tlvef_pkg::rsp_payload_type result_ff;
   tlvef_pkg::rsp_payload_type result_in;
   logic                       rsp_valid_ff;
   logic                       rsp_valid_in;
   logic                       req_xfer;

   assign req_if.ready = !rsp_valid_ff || rsp_if.ready;
   assign req_xfer     = req_if.valid && req_if.ready;

   tlvef_step #(
      .CNT_W (CntW)
   ) u_step (
      .req        (req_if.payload),
      .state      (state_ff),
      .count      (count_ff),
      .state_next (state_in),
      .count_next (count_in),
      .result     (result_in)
   );

   always_comb begin
      if (req_xfer) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase       <= tlvef_pkg::PH_TYPE;
         state_ff.header_left <= '0;
         state_ff.value_left  <= '0;
         state_ff.end_reached <= 1'b0;
         count_ff             <= '0;
         rsp_valid_ff         <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_xfer) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         result_ff <= result_in;
      end
   end

   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = result_ff;

   // the end flag is only ever held together with the done phase
   a_end_in_done: assert property (@(posedge clock) disable iff (reset)
      state_ff.end_reached |-> state_ff.phase == tlvef_pkg::PH_DONE)
      else $error("end reached outside done phase");

   // a byte transfer always leaves a result behind
   a_xfer_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> rsp_valid_ff)
      else $error("byte transfer without a result");

   // a stalled result must not be overwritten
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_if.ready) |-> !req_xfer)
      else $error("result overwritten while stalled");

   a_end_not_ignored: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(result_ff.element_end && result_ff.ignored))
      else $error("result both ends element and is ignored");

   a_end_phase: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && result_ff.element_end)
         |-> result_ff.phase == tlvef_pkg::PHASE_CODE_DONE)
      else $error("element end reported outside done phase");

endmodule

FILE: rtl/tlvef_step.sv
// next-state and result logic for one byte of the element parser
module tlvef_step #(
   parameter int CNT_W = 32
) (
   input  tlvef_pkg::req_payload_type req,
   input  tlvef_pkg::parse_state_type state,
   input  logic [CNT_W-1:0]           count,
   output tlvef_pkg::parse_state_type state_next,
   output logic [CNT_W-1:0]           count_next,
   output tlvef_pkg::rsp_payload_type result
);

   tlvef_pkg::parse_state_type cur;
   logic [CNT_W-1:0]           cur_count;
   logic                       was_done;
   logic                       ignored;
   logic [3:0]                 hdr_dec;
   logic [63:0]                val_shift;
   logic [63:0]                val_dec;
   logic                       short_code;

   always_comb begin
      // restart clears everything before the byte is looked at
      if (req.mode) begin
         cur.phase       = tlvef_pkg::PH_TYPE;
         cur.header_left = '0;
         cur.value_left  = '0;
         cur.end_reached = 1'b0;
         cur_count       = '0;
      end else begin
         cur       = state;
         cur_count = count;
      end

      was_done   = cur.end_reached;
      short_code = (req.data_byte < tlvef_pkg::EXT2_OCTET);
      hdr_dec    = cur.header_left - 4'd1;
      val_shift  = {cur.value_left[55:0], req.data_byte};
      val_dec    = cur.value_left - 64'd1;

      state_next = cur;
      count_next = cur_count;
      ignored    = 1'b0;

      if (cur.end_reached || cur.phase == tlvef_pkg::PH_DONE) begin
         ignored                = 1'b1;
         state_next.end_reached = 1'b1;
         state_next.phase       = tlvef_pkg::PH_DONE;
      end else begin
         if (cur_count != {CNT_W{1'b1}}) begin
            count_next = cur_count + CNT_W'(1);
         end
         case (cur.phase)
            tlvef_pkg::PH_TYPE: begin
               if (short_code) begin
                  state_next.phase = tlvef_pkg::PH_LENGTH;
               end else begin
                  state_next.header_left = tlvef_pkg::ext_bytes(req.data_byte);
                  state_next.phase       = tlvef_pkg::PH_TYPE_BYTES;
               end
            end
            tlvef_pkg::PH_TYPE_BYTES: begin
               state_next.header_left = hdr_dec;
               if (hdr_dec == 4'd0) begin
                  state_next.phase = tlvef_pkg::PH_LENGTH;
               end
            end
            tlvef_pkg::PH_LENGTH: begin
               if (short_code) begin
                  state_next.value_left = {56'd0, req.data_byte};
                  if (req.data_byte == 8'd0) begin
                     state_next.end_reached = 1'b1;
                     state_next.phase       = tlvef_pkg::PH_DONE;
                  end else begin
                     state_next.phase = tlvef_pkg::PH_VALUE;
                  end
               end else begin
                  state_next.header_left = tlvef_pkg::ext_bytes(req.data_byte);
                  state_next.value_left  = '0;
                  state_next.phase       = tlvef_pkg::PH_LENGTH_BYTES;
               end
            end
            tlvef_pkg::PH_LENGTH_BYTES: begin
               state_next.value_left  = val_shift;
               state_next.header_left = hdr_dec;
               if (hdr_dec == 4'd0) begin
                  if (val_shift == 64'd0) begin
                     state_next.end_reached = 1'b1;
                     state_next.phase       = tlvef_pkg::PH_DONE;
                  end else begin
                     state_next.phase = tlvef_pkg::PH_VALUE;
                  end
               end
            end
            default: begin
               // value phase: count down the value bytes
               state_next.value_left = val_dec;
               if (val_dec == 64'd0) begin
                  state_next.end_reached = 1'b1;
                  state_next.phase       = tlvef_pkg::PH_DONE;
               end
            end
         endcase
      end

      result.element_end    = state_next.end_reached && !was_done && !ignored;
      result.ignored        = ignored;
      result.phase          = tlvef_pkg::phase_code(state_next.phase);
      result.bytes_consumed = 32'(count_next);
   end

endmodule

FILE: tb/testbench.sv
// testbench for the tlv element end finder: directed and random byte streams checked by a predictor
`timescale 1ns / 1ps

module testbench;

   localparam int COUNT_WIDTH = 32;
   localparam logic [31:0] COUNT_CAP =
      (COUNT_WIDTH >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << COUNT_WIDTH) - 64'd1);
   localparam logic [7:0] EXT8_OCTET = 8'd255;
   localparam int LONG_HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 600;

   typedef struct packed {
      logic [2:0]  phase;
      logic [3:0]  header_left;
      logic [63:0] value_left;
      logic [31:0] consumed;
      logic        end_reached;
   } parser_state_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   tlvef_stream_if #(.payload_type(tlvef_pkg::req_payload_type)) req_if ();
   tlvef_stream_if #(.payload_type(tlvef_pkg::rsp_payload_type)) rsp_if ();

   tlv_element_end_finder #(.COUNT_WIDTH(COUNT_WIDTH)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   logic                       send_valid = 1'b0;
   tlvef_pkg::req_payload_type send_item = '0;
   logic                       take_ready = 1'b0;
   logic                       byte_taken = 1'b0;

   assign req_if.valid   = send_valid;
   assign req_if.payload = send_item;
   assign rsp_if.ready   = take_ready;

   tlvef_pkg::req_payload_type pending_bytes[$];
   tlvef_pkg::rsp_payload_type expected_results[$];
   parser_state_type parser;
   int  counted_items = 0;
   int  error_count = 0;
   int  sender_idle_pct = 17;
   int  receiver_idle_pct = 65;
   bit  hold_off = 1'b0;
   int  held_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [3:0] announced_bytes(input logic [7:0] octet);
      logic [3:0] n;
      case (octet)
         tlvef_pkg::EXT2_OCTET: n = tlvef_pkg::EXT2_BYTES;
         tlvef_pkg::EXT4_OCTET: n = tlvef_pkg::EXT4_BYTES;
         default:               n = tlvef_pkg::EXT8_BYTES;
      endcase
      return n;
   endfunction

   // advances the parser by one byte and returns the result it should report
   function automatic tlvef_pkg::rsp_payload_type advance_parser(
      input tlvef_pkg::req_payload_type item);
      tlvef_pkg::rsp_payload_type res;
      logic was_done;
      logic skipped;
      if (item.mode) begin
         parser = '0;
         parser.phase = tlvef_pkg::PHASE_CODE_TYPE;
      end
      was_done = parser.end_reached;
      skipped = 1'b0;
      if (parser.end_reached || parser.phase > tlvef_pkg::PHASE_CODE_VALUE) begin
         skipped = 1'b1;
         parser.end_reached = 1'b1;
         parser.phase = tlvef_pkg::PHASE_CODE_DONE;
      end else begin
         if (parser.consumed < COUNT_CAP) begin
            parser.consumed = parser.consumed + 32'd1;
         end
         case (parser.phase)
            tlvef_pkg::PHASE_CODE_TYPE: begin
               if (item.data_byte < tlvef_pkg::EXT2_OCTET) begin
                  parser.phase = tlvef_pkg::PHASE_CODE_LENGTH;
               end else begin
                  parser.header_left = announced_bytes(item.data_byte);
                  parser.phase = tlvef_pkg::PHASE_CODE_TYPE_BYTES;
               end
            end
            tlvef_pkg::PHASE_CODE_TYPE_BYTES: begin
               parser.header_left = parser.header_left - 4'd1;
               if (parser.header_left == 4'd0) begin
                  parser.phase = tlvef_pkg::PHASE_CODE_LENGTH;
               end
            end
            tlvef_pkg::PHASE_CODE_LENGTH: begin
               if (item.data_byte < tlvef_pkg::EXT2_OCTET) begin
                  parser.value_left = 64'(item.data_byte);
                  if (item.data_byte == 8'd0) begin
                     parser.end_reached = 1'b1;
                     parser.phase = tlvef_pkg::PHASE_CODE_DONE;
                  end else begin
                     parser.phase = tlvef_pkg::PHASE_CODE_VALUE;
                  end
               end else begin
                  parser.header_left = announced_bytes(item.data_byte);
                  parser.value_left = '0;
                  parser.phase = tlvef_pkg::PHASE_CODE_LENGTH_BYTES;
               end
            end
            tlvef_pkg::PHASE_CODE_LENGTH_BYTES: begin
               parser.value_left = {parser.value_left[55:0], item.data_byte};
               parser.header_left = parser.header_left - 4'd1;
               if (parser.header_left == 4'd0) begin
                  if (parser.value_left == 64'd0) begin
                     parser.end_reached = 1'b1;
                     parser.phase = tlvef_pkg::PHASE_CODE_DONE;
                  end else begin
                     parser.phase = tlvef_pkg::PHASE_CODE_VALUE;
                  end
               end
            end
            default: begin
               parser.value_left = parser.value_left - 64'd1;
               if (parser.value_left == 64'd0) begin
                  parser.end_reached = 1'b1;
                  parser.phase = tlvef_pkg::PHASE_CODE_DONE;
               end
            end
         endcase
      end
      res.element_end = parser.end_reached && !was_done && !skipped;
      res.ignored = skipped;
      res.phase = parser.phase;
      res.bytes_consumed = parser.consumed;
      return res;
   endfunction

   task automatic check_result(input tlvef_pkg::rsp_payload_type got);
      tlvef_pkg::rsp_payload_type want;
      if (expected_results.size() == 0) begin
         $error("result transfer with no byte outstanding");
         error_count++;
      end else begin
         want = expected_results.pop_front();
         if (got.element_end !== want.element_end) begin
            $error("element_end: expected %0d, actual %0d",
                   want.element_end, got.element_end);
            error_count++;
         end
         if (got.ignored !== want.ignored) begin
            $error("ignored: expected %0d, actual %0d", want.ignored, got.ignored);
            error_count++;
         end
         if (got.phase !== want.phase) begin
            $error("phase: expected %0d, actual %0d", want.phase, got.phase);
            error_count++;
         end
         if (got.bytes_consumed !== want.bytes_consumed) begin
            $error("bytes_consumed: expected %0d, actual %0d",
                   want.bytes_consumed, got.bytes_consumed);
            error_count++;
         end
      end
   endtask

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         byte_taken <= 1'b0;
         parser = '0;
         parser.phase = tlvef_pkg::PHASE_CODE_TYPE;
      end else begin
         byte_taken <= req_if.valid && req_if.ready;
         if (rsp_if.valid && rsp_if.ready) begin
            check_result(rsp_if.payload);
         end
         if (req_if.valid && req_if.ready) begin
            expected_results.push_back(advance_parser(req_if.payload));
         end
      end
   end

   // driver: a byte stays offered until its transfer
   always @(negedge clock) begin
      if (reset) begin
         send_valid <= 1'b0;
      end else if (!send_valid || byte_taken) begin
         if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= sender_idle_pct) begin
            send_item <= pending_bytes.pop_front();
            send_valid <= 1'b1;
         end else begin
            send_valid <= 1'b0;
         end
      end
   end

   // receiver: random stalls plus one long hold-off
   always @(negedge clock) begin
      if (reset) begin
         take_ready <= 1'b0;
      end else if (hold_off && held_cycles < LONG_HOLD_CYCLES) begin
         take_ready <= 1'b0;
         held_cycles <= held_cycles + 1;
      end else begin
         take_ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   task automatic add_byte(input logic [7:0] value, input logic restart, input bit counted);
      tlvef_pkg::req_payload_type p;
      p.data_byte = value;
      p.mode = restart;
      pending_bytes.push_back(p);
      if (counted) begin
         counted_items++;
      end
   endtask

   // one element with random type and length forms, sometimes cut short
   task automatic add_element();
      logic [7:0]  body[$];
      logic [7:0]  octet;
      logic [63:0] len;
      int pick;
      int nbytes;
      int nvalue;
      int cut;
      int k;
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         body.push_back(8'($urandom_range(0, 252)));
      end else begin
         octet = (pick == 6) ? tlvef_pkg::EXT2_OCTET :
                 (pick == 7) ? tlvef_pkg::EXT4_OCTET : EXT8_OCTET;
         body.push_back(octet);
         nbytes = int'(announced_bytes(octet));
         for (k = 0; k < nbytes; k++) begin
            body.push_back(8'($urandom_range(0, 255)));
         end
      end
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
         len = '0;
      end else if (pick == 1) begin
         len = {$urandom, $urandom};
      end else if (pick == 2) begin
         len = 64'($urandom_range(25, 300));
      end else begin
         len = 64'($urandom_range(1, 24));
      end
      if (len < 64'd253 && $urandom_range(0, 3) != 0) begin
         body.push_back(len[7:0]);
      end else begin
         pick = $urandom_range(0, 2);
         if (len > 64'hFFFF_FFFF) begin
            octet = EXT8_OCTET;
         end else if (len > 64'hFFFF) begin
            octet = (pick == 0) ? tlvef_pkg::EXT4_OCTET : EXT8_OCTET;
         end else begin
            octet = (pick == 0) ? tlvef_pkg::EXT2_OCTET :
                    (pick == 1) ? tlvef_pkg::EXT4_OCTET : EXT8_OCTET;
         end
         body.push_back(octet);
         nbytes = int'(announced_bytes(octet));
         for (k = nbytes - 1; k >= 0; k--) begin
            body.push_back(len[8*k +: 8]);
         end
      end
      // huge lengths get a few value bytes and are then abandoned by a restart
      nvalue = (len > 64'd300) ? $urandom_range(0, 8) : int'(len);
      for (k = 0; k < nvalue; k++) begin
         body.push_back(8'($urandom_range(0, 255)));
      end
      cut = body.size();
      if ($urandom_range(0, 9) == 0) begin
         cut = $urandom_range(1, body.size());
      end
      for (k = 0; k < cut; k++) begin
         add_byte(body[k], k == 0, 1'b1);
      end
      if (cut == body.size() && len <= 64'd300) begin
         repeat ($urandom_range(0, 2)) add_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
   endtask

   task automatic add_random_phase(input int quota);
      int start;
      start = counted_items;
      while (counted_items - start < quota) begin
         add_element();
         if ($urandom_range(0, 11) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 2) == 0, 1'b1);
            end
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_bytes.size() != 0 || send_valid || expected_results.size() != 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      logic [7:0] lead_bytes [0:24];
      logic       lead_restart [0:24];
      // zero length, trailing byte, short value, extended type and zero extended
      // length, very long extended length, restart in the middle of a type
      lead_bytes = '{8'h00, 8'h00, 8'hFF, 8'hFC, 8'h01, 8'h55, tlvef_pkg::EXT2_OCTET,
                     8'h12, 8'h34, tlvef_pkg::EXT2_OCTET, 8'h00, 8'h00, 8'h01, EXT8_OCTET,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hAA,
                     tlvef_pkg::EXT4_OCTET, 8'h00};
      lead_restart = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0,
                       1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0,
                       1'b0, 1'b0, 1'b0, 1'b1, 1'b0};
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 25; i++) begin
         add_byte(lead_bytes[i], lead_restart[i], 1'b1);
      end
      add_random_phase(PHASE_ITEMS);
      wait_drained();
      sender_idle_pct = 65;
      receiver_idle_pct = 17;
      add_random_phase(PHASE_ITEMS);
      wait_drained();
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      hold_off = 1'b1;
      add_random_phase(PHASE_ITEMS);
      wait_drained();
      repeat (10) @(posedge clock);
      if (error_count == 0 && expected_results.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
